// ===== sv/star_pkg.sv =====
// Package with shared types and constants for the score table block.
package star_pkg;

    localparam int MaxStudents = 64;
    localparam int MaxSubjects = 16;
    localparam int StW = 6;
    localparam int SjW = 4;
    localparam int AddrW = StW + SjW;
    localparam int Depth = MaxStudents * MaxSubjects;
    localparam logic [6:0] ScoreCap = 7'd100;

    localparam logic [0:0] CmdWrite = 1'b0;
    localparam logic [0:0] CmdQuery = 1'b1;

    localparam logic [0:0] RegNumStudents = 1'b0;
    localparam logic [0:0] RegNumSubjects = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [5:0] student;
        logic [3:0] subject;
        logic [9:0] score;
    } t_in;

    typedef struct packed {
        logic       status;
        logic [6:0] entry_score;
        logic [6:0] subject_rank;
        logic [6:0] subject_mean;
        logic [6:0] student_mean;
        logic [6:0] overall_rank;
    } t_out;

    // Memory port request from the sequencer to the score memory.
    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] addr;
        logic [6:0]       wdata;
    } t_mem_req;

endpackage

// ===== sv/star_mem.sv =====
// Score memory: one write or read port, registered read data.
module star_mem (
    input  logic                  i_clk,
    input  star_pkg::t_mem_req    i_req,
    output logic [6:0]            o_rdata
);
    import star_pkg::*;

    logic [6:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end
endmodule

// ===== sv/star_div.sv =====
// Restoring divider: 13-bit dividend by 7-bit divisor, one bit a cycle.
module star_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_num,
    input  logic [6:0]  i_den,
    output logic        o_busy,
    output logic [12:0] o_quot
);
    import star_pkg::*;

    logic [3:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [12:0] r_q, n_q;
    logic [7:0]  r_rem, n_rem;
    logic [6:0]  r_den;
    logic [7:0]  w_sh;

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_q = r_q;
        n_rem = r_rem;
        w_sh = {r_rem[6:0], r_q[12]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = 4'd0;
            n_q = i_num;
            n_rem = 8'd0;
        end else if (r_busy) begin
            n_q = {r_q[11:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd12) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

// ===== sv/score_table_average_rank_top.sv =====
// Top level of the score table with subject and student means and ranks.
//
//  channel  | signals                      | payload
//  ---------+------------------------------+----------------------------
//  input    | i_valid / o_ready            | i_data   (star_pkg::t_in)
//  output   | o_valid / i_ready            | o_data   (star_pkg::t_out)
//  config   | i_cfg_we, i_cfg_index        | i_cfg_data (7 bits)
//
// After reset a clearing pass writes zero to all 1024 score entries, one
// entry a cycle, and no transaction is accepted until it has ended.
// A transaction then runs through a sequencer around the single-port score
// memory: an optional write, a walk down the addressed subject column (one
// read a cycle) and a serial division for the column mean, then a walk
// along the addressed student's row and a serial division for its mean; a
// query then walks rows 0..ns-1 in the same way to rank the row means.
// An item with an out-of-range index gets its result in the cycle after
// acceptance. The result sits in an output register; the next input
// transaction is taken once that register has been handed off.
module score_table_average_rank_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  star_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output star_pkg::t_out    o_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [6:0]        i_cfg_data
);
    import star_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_COL   = 9'b000000100,
        S_CDIV  = 9'b000001000,
        S_ROW   = 9'b000010000,
        S_RDIV  = 9'b000100000,
        S_RWAIT = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [6:0]  r_cfg_ns, r_cfg_nj;
    logic [6:0]  w_ns;
    logic [4:0]  w_nj;
    logic [AddrW:0] r_clr, n_clr;

    t_in         r_in, n_in;
    logic [6:0]  r_mine, n_mine;
    logic [6:0]  r_srank, n_srank;
    logic [6:0]  r_orank, n_orank;
    logic [12:0] r_csum, n_csum;
    logic [10:0] r_rsum, n_rsum;
    logic [6:0]  r_smean, n_smean;
    logic [6:0]  r_cmean, n_cmean;
    logic [6:0]  r_pass, n_pass;     // 0: own row first, then rows 0..ns-1
    logic [6:0]  r_u, n_u;
    logic [4:0]  r_j, n_j;
    logic        r_rdv, n_rdv;
    logic        r_last, n_last;
    logic        r_ovalid, n_ovalid;
    t_out        r_out, n_out;

    t_mem_req    w_req;
    logic [6:0]  w_rdata;
    logic        w_dstart;
    logic [12:0] w_dnum;
    logic [6:0]  w_dden;
    logic        w_dbusy;
    logic [12:0] w_dquot;
    logic [6:0]  w_wsc;
    logic [5:0]  w_row;

    star_mem u_mem (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    star_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_busy(w_dbusy), .o_quot(w_dquot)
    );

    // Counts out of range are pulled into their legal span.
    assign w_ns = (r_cfg_ns == 7'd0) ? 7'd1 :
                  (r_cfg_ns > 7'd64) ? 7'd64 : r_cfg_ns;
    assign w_nj = (r_cfg_nj == 7'd0) ? 5'd1 :
                  (r_cfg_nj > 7'd16) ? 5'd16 : r_cfg_nj[4:0];

    assign w_wsc = (i_data.score > 10'd100) ? ScoreCap : i_data.score[6:0];
    // Pass 0 walks the addressed student's row; later passes walk row u.
    assign w_row = (r_pass == 7'd0) ? r_in.student : r_u[5:0];

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_in = r_in;
        n_mine = r_mine;
        n_srank = r_srank;
        n_orank = r_orank;
        n_csum = r_csum;
        n_rsum = r_rsum;
        n_smean = r_smean;
        n_cmean = r_cmean;
        n_pass = r_pass;
        n_u = r_u;
        n_j = r_j;
        n_rdv = 1'b0;
        n_last = 1'b0;
        n_ovalid = r_ovalid;
        n_out = r_out;
        w_req = '{we: 1'b0, addr: '0, wdata: '0};
        w_dstart = 1'b0;
        w_dnum = r_csum;
        w_dden = w_ns;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_req = '{we: 1'b1, addr: r_clr[AddrW-1:0], wdata: 7'd0};
                n_clr = r_clr + (AddrW+1)'(1);
                if (r_clr[AddrW-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_in = i_data;
                    n_csum = '0;
                    n_srank = 7'd1;
                    n_orank = 7'd1;
                    n_u = 7'd0;
                    n_out = '0;
                    if ({1'b0, i_data.student} >= w_ns ||
                        {1'b0, i_data.subject} >= w_nj) begin
                        n_out.status = 1'b1;
                        n_ovalid = 1'b1;
                    end else begin
                        if (i_data.cmd == CmdWrite) begin
                            w_req = '{we: 1'b1, addr: {i_data.student, i_data.subject},
                                      wdata: w_wsc};
                        end
                        n_state = S_COL;
                    end
                end
            end
            S_COL: begin
                // Addressed entry is read first, then column rows 0..ns-1.
                if (r_u <= w_ns) begin
                    w_req.addr = (r_u == 7'd0) ? {r_in.student, r_in.subject}
                                               : {r_u[5:0] - 6'd1, r_in.subject};
                    n_rdv = 1'b1;
                    n_u = r_u + 7'd1;
                end
                if (r_rdv) begin
                    if (r_u == 7'd1) begin
                        n_mine = w_rdata;
                    end else begin
                        n_csum = r_csum + {6'd0, w_rdata};
                        if (w_rdata > r_mine) begin
                            n_srank = r_srank + 7'd1;
                        end
                    end
                end
                if (r_u == w_ns + 7'd1 && !r_rdv) begin
                    n_state = S_CDIV;
                    w_dstart = 1'b1;
                end
            end
            S_CDIV: begin
                if (!w_dbusy && !w_dstart) begin
                    n_cmean = w_dquot[6:0];
                    n_pass = 7'd0;
                    n_u = 7'd0;
                    n_j = 5'd0;
                    n_rsum = '0;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (r_j < w_nj) begin
                    w_req.addr = {w_row, r_j[3:0]};
                    n_rdv = 1'b1;
                    n_j = r_j + 5'd1;
                    n_last = (r_j == w_nj - 5'd1);
                end
                if (r_rdv) begin
                    n_rsum = r_rsum + {4'd0, w_rdata};
                end
                if (r_last) begin
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                w_dstart = 1'b1;
                w_dnum = {2'd0, r_rsum};
                w_dden = {2'd0, w_nj};
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                if (!w_dbusy) begin
                    n_rsum = '0;
                    n_j = 5'd0;
                    if (r_pass == 7'd0) begin
                        n_smean = w_dquot[6:0];
                        if (r_in.cmd == CmdWrite) begin
                            n_state = S_DONE;
                        end else begin
                            n_pass = 7'd1;
                            n_u = 7'd0;
                            n_state = S_ROW;
                        end
                    end else begin
                        if (w_dquot[6:0] > r_smean) begin
                            n_orank = r_orank + 7'd1;
                        end
                        n_u = r_u + 7'd1;
                        if (r_u + 7'd1 == w_ns) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ROW;
                        end
                    end
                end
            end
            S_DONE: begin
                n_out.status = 1'b0;
                n_out.subject_mean = r_cmean;
                n_out.student_mean = r_smean;
                if (r_in.cmd == CmdQuery) begin
                    n_out.entry_score = r_mine;
                    n_out.subject_rank = r_srank;
                    n_out.overall_rank = r_orank;
                end
                n_ovalid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_rdv <= 1'b0;
            r_last <= 1'b0;
            r_cfg_ns <= 7'd1;
            r_cfg_nj <= 7'd1;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
            r_rdv <= n_rdv;
            r_last <= n_last;
            if (i_cfg_we && i_cfg_index == RegNumStudents) begin
                r_cfg_ns <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == RegNumSubjects) begin
                r_cfg_nj <= {2'd0, i_cfg_data[4:0]};
            end
        end
        r_in <= n_in;
        r_mine <= n_mine;
        r_srank <= n_srank;
        r_orank <= n_orank;
        r_csum <= n_csum;
        r_rsum <= n_rsum;
        r_smean <= n_smean;
        r_cmean <= n_cmean;
        r_pass <= n_pass;
        r_u <= n_u;
        r_j <= n_j;
        r_out <= n_out;
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_srank <= w_ns && r_orank <= w_ns))
        else $error("rank beyond count");
endmodule
